// ===== design/kmtf_pkg.sv =====
// Package for the keyed move-to-front thread table.
// Holds field widths, default sizes, result status codes and the
// command and status bundles between the controller and the datapath.
package kmtf_pkg;

	// Fixed field widths of the channels.
	localparam int KEY_W    = 60;
	localparam int STATUS_W = 2;
	localparam int RANK_W   = 4;
	localparam int MSGIDX_W = 5;
	localparam int TOTAL_W  = 5;

	// Default table sizes.
	localparam int THREAD_SLOTS_DEF = 16;
	localparam int MSGS_PER_THREAD_DEF = 32;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_APPEND = 2'd0;
	localparam logic [STATUS_W-1:0] ST_CREATE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_DROP   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;      // latch an accepted event and restart the search
		logic srch;      // issue the next search read
		logic hit;       // capture the matching entry
		logic upd;       // decide the outcome and append the message
		logic shift;     // move one entry down one place
		logic wtop;      // write the promoted entry at the top
		logic res_load;  // hand the result to the output register
	} kmtf_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic match;     // entry read last cycle holds the key
		logic more;      // entries remain to be read
		logic pend;      // a read is in flight
		logic found;     // the event hit a stored thread
		logic full;      // every thread slot is in use
		logic out_free;  // the output register can take a result
	} kmtf_sts_t;

endpackage

// ===== design/keyed_move_to_front_table.sv =====
// Keyed move-to-front thread table, top level.
// Depends on kmtf_pkg, kmtf_ctrl and kmtf_datapath.
//
// Each event on the input channel (in_valid, in_stall, phone_key,
// direction) is looked up among the held threads. A known key appends
// the direction bit to its thread; an unknown key opens a new thread if
// a slot is free, otherwise the event is dropped. Unless dropped, the thread is
// then moved to the most recent position. One result per event leaves on the
// output channel (out_valid, out_stall, status, prior_rank, message_index,
// thread_total); a transfer happens at a rising edge with valid high, stall low.
// Events are handled one at a time. The search reads the held threads
// from slot 0 upward until the key matches or none remain; an update
// step decides the outcome; the entries above the thread's slot are
// shifted down one place and the thread is written at the top (no shift
// on a drop); then the result is handed to the output register and the
// next event can be taken. The thread RAM gives one read a cycle for the
// search and for the shift, so the shift moves one entry at a time.
// While a result waits in the output register the next event is taken;
// its result and the input wait until out_stall is low. Reset clears the
// thread count and the controller; the RAM is only read below the count.
module keyed_move_to_front_table import kmtf_pkg::*; #(
	parameter int THREAD_SLOTS        = THREAD_SLOTS_DEF,
	parameter int MESSAGES_PER_THREAD = MSGS_PER_THREAD_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [KEY_W-1:0]    phone_key,
	input  logic                direction,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [STATUS_W-1:0] status,
	output logic [RANK_W-1:0]   prior_rank,
	output logic [MSGIDX_W-1:0] message_index,
	output logic [TOTAL_W-1:0]  thread_total
);

	kmtf_cmd_t cmd;
	kmtf_sts_t sts;

	// Sequencer.
	kmtf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Thread storage and result logic.
	kmtf_datapath #(
		.THREAD_SLOTS        (THREAD_SLOTS),
		.MESSAGES_PER_THREAD (MESSAGES_PER_THREAD)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.phone_key     (phone_key),
		.direction     (direction),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.status        (status),
		.prior_rank    (prior_rank),
		.message_index (message_index),
		.thread_total  (thread_total)
	);

endmodule

// ===== design/kmtf_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing else in the project.
module kmtf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== design/kmtf_datapath.sv =====
// Datapath of the thread table: thread RAM, search and shift pointers,
// message append logic and the output register.
// Depends on kmtf_pkg and kmtf_ram.
module kmtf_datapath import kmtf_pkg::*; #(
	parameter int THREAD_SLOTS        = THREAD_SLOTS_DEF,
	parameter int MESSAGES_PER_THREAD = MSGS_PER_THREAD_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  kmtf_cmd_t           cmd,
	output kmtf_sts_t           sts,
	input  logic [KEY_W-1:0]    phone_key,
	input  logic                direction,
	input  logic                out_stall,
	output logic                out_valid,
	output logic [STATUS_W-1:0] status,
	output logic [RANK_W-1:0]   prior_rank,
	output logic [MSGIDX_W-1:0] message_index,
	output logic [TOTAL_W-1:0]  thread_total
);

	localparam int SLOT_W = $clog2(THREAD_SLOTS);
	localparam int USED_W = $clog2(THREAD_SLOTS + 1);
	localparam int CNT_W  = $clog2(MESSAGES_PER_THREAD + 1);
	localparam int MPT    = MESSAGES_PER_THREAD;
	localparam int ENT_W  = KEY_W + CNT_W + MPT;

	// Registers.
	logic [KEY_W-1:0]    key_q;
	logic                dir_q;
	logic [USED_W-1:0]   used_q;
	logic [USED_W-1:0]   idx_q;
	logic [SLOT_W-1:0]   cmp_idx_q;
	logic                cmp_vld_q;
	logic                found_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [SLOT_W-1:0]   wp_q;
	logic [ENT_W-1:0]    ent_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [USED_W-1:0]   res_rank_q;
	logic [CNT_W-1:0]    res_msg_q;
	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [RANK_W-1:0]   prior_rank_q;
	logic [MSGIDX_W-1:0] message_index_q;
	logic [TOTAL_W-1:0]  thread_total_q;

	// RAM ports and combinational values.
	logic                ram_we;
	logic [SLOT_W-1:0]   ram_waddr;
	logic [ENT_W-1:0]    ram_wdata;
	logic [ENT_W-1:0]    ram_rdata;
	logic                issue;
	logic                more;
	logic                full;
	logic [SLOT_W-1:0]   top;
	logic [SLOT_W-1:0]   upd_slot;
	logic [CNT_W-1:0]    base_cnt;
	logic [MPT-1:0]      base_dirs;
	logic [CNT_W-1:0]    new_cnt;
	logic [MPT-1:0]      new_dirs;
	logic [CNT_W-1:0]    upd_msg;
	logic [STATUS_W-1:0] upd_status;
	logic [31:0]         rank_ext;
	logic [31:0]         msg_ext;
	logic [31:0]         total_ext;

	kmtf_ram #(
		.WIDTH (ENT_W),
		.DEPTH (THREAD_SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (idx_q[SLOT_W-1:0]),
		.rdata (ram_rdata)
	);

	// Status towards the controller.
	assign more  = idx_q < used_q;
	assign full  = used_q == USED_W'(THREAD_SLOTS);
	assign top   = SLOT_W'(used_q - USED_W'(1));
	assign issue = cmd.srch || (cmd.shift && more);

	always_comb begin
		sts          = '0;
		sts.match    = cmp_vld_q && (ram_rdata[ENT_W-1 -: KEY_W] == key_q);
		sts.more     = more;
		sts.pend     = cmp_vld_q;
		sts.found    = found_q;
		sts.full     = full;
		sts.out_free = !out_valid_q || !out_stall;
	end

	// Shift writes move the entry just read down one place; the final
	// write puts the promoted entry at the top.
	always_comb begin
		ram_we    = (cmd.shift && cmp_vld_q) || cmd.wtop;
		ram_waddr = cmd.wtop ? top : wp_q;
		ram_wdata = cmd.wtop ? ent_q : ram_rdata;
	end

	// Append the direction bit to the hit entry or to a fresh one.
	always_comb begin
		if (found_q) begin
			upd_slot  = slot_q;
			base_cnt  = ent_q[MPT +: CNT_W];
			base_dirs = ent_q[MPT-1:0];
		end else begin
			upd_slot  = used_q[SLOT_W-1:0];
			base_cnt  = '0;
			base_dirs = '0;
		end
		if (base_cnt < CNT_W'(MPT)) begin
			new_cnt    = base_cnt + CNT_W'(1);
			new_dirs   = base_dirs | (MPT'(dir_q) << base_cnt);
			upd_msg    = base_cnt;
			upd_status = found_q ? ST_APPEND : ST_CREATE;
		end else begin
			new_cnt    = base_cnt;
			new_dirs   = base_dirs;
			upd_msg    = CNT_W'(MPT - 1);
			upd_status = ST_FULL;
		end
	end

	// Control registers of the search, shift and thread count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q    <= '0;
			cmp_vld_q <= 1'b0;
			found_q   <= 1'b0;
		end else begin
			cmp_vld_q <= issue;
			if (cmd.load) begin
				found_q <= 1'b0;
			end else if (cmd.hit) begin
				found_q <= 1'b1;
			end
			if (cmd.upd && !found_q && !full) begin
				used_q <= used_q + USED_W'(1);
			end
		end
	end

	// Event, pointer and entry registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q <= phone_key;
			dir_q <= direction;
			idx_q <= '0;
		end else if (cmd.upd) begin
			idx_q <= USED_W'(upd_slot) + USED_W'(1);
		end else if (issue) begin
			idx_q <= idx_q + USED_W'(1);
		end
		if (issue) begin
			cmp_idx_q <= idx_q[SLOT_W-1:0];
		end
		if (cmd.hit) begin
			slot_q <= cmp_idx_q;
			ent_q  <= ram_rdata;
		end
		if (cmd.upd) begin
			wp_q  <= upd_slot;
			ent_q <= found_q ? {ent_q[ENT_W-1 -: KEY_W], new_cnt, new_dirs}
			                 : {key_q, new_cnt, new_dirs};
			if (!found_q && full) begin
				res_status_q <= ST_DROP;
				res_msg_q    <= '0;
			end else begin
				res_status_q <= upd_status;
				res_msg_q    <= upd_msg;
			end
			if (found_q) begin
				res_rank_q <= used_q - USED_W'(1) - USED_W'(slot_q);
			end else begin
				res_rank_q <= '0;
			end
		end else if (cmd.shift && cmp_vld_q) begin
			wp_q <= wp_q + SLOT_W'(1);
		end
	end

	// Output register: a result waits here while the next event is taken.
	assign rank_ext  = 32'(res_rank_q);
	assign msg_ext   = 32'(res_msg_q);
	assign total_ext = 32'(used_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			status_q        <= res_status_q;
			prior_rank_q    <= rank_ext[RANK_W-1:0];
			message_index_q <= msg_ext[MSGIDX_W-1:0];
			thread_total_q  <= total_ext[TOTAL_W-1:0];
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign prior_rank    = prior_rank_q;
	assign message_index = message_index_q;
	assign thread_total  = thread_total_q;

endmodule

// ===== design/kmtf_ctrl.sv =====
// Controller of the thread table: sequences search, update, shift and
// result hand-over for one event at a time.
// Depends on kmtf_pkg.
module kmtf_ctrl import kmtf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  kmtf_sts_t sts,
	output kmtf_cmd_t cmd
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_SRCH  = 5'b00010,
		S_UPD   = 5'b00100,
		S_SHIFT = 5'b01000,
		S_RES   = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_SRCH;
				end
			end
			S_SRCH: begin
				if (sts.match) begin
					cmd.hit = 1'b1;
					state_d = S_UPD;
				end else if (!sts.more) begin
					state_d = S_UPD;
				end else begin
					cmd.srch = 1'b1;
				end
			end
			S_UPD: begin
				cmd.upd = 1'b1;
				if (!sts.found && sts.full) begin
					state_d = S_RES;
				end else begin
					state_d = S_SHIFT;
				end
			end
			S_SHIFT: begin
				if (sts.more || sts.pend) begin
					cmd.shift = 1'b1;
				end else begin
					cmd.wtop = 1'b1;
					state_d  = S_RES;
				end
			end
			S_RES: begin
				if (sts.out_free) begin
					cmd.res_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
